// ----- design/bds_pkg.sv -----
// ----------------------------------------------------------------------------
// bds_pkg
// Shared types and constants for the 2x2 box downsampler.
// ----------------------------------------------------------------------------
package bds_pkg;

	// Widths of the configuration registers and of one pixel byte.
	localparam int CFG_W      = 13;
	localparam int CHAN_CNT_W = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int BYTE_W     = 8;

	// Fixed number of channels on the pixel and result channels.
	localparam int PORT_CHANNELS = 4;

	// Largest frame height and the width of the row position counter.
	localparam int MAX_HEIGHT = 4096;
	localparam int ROW_W      = 12;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

	// One pixel, one byte per channel.
	typedef logic [PORT_CHANNELS-1:0][BYTE_W-1:0] pix_t;

	// Position flags of one accepted pixel, handed from the scan stage on.
	typedef struct packed {
		logic emit;
		logic last_col;
		logic last_row;
		logic odd_row;
		logic first_col;
	} scan_info_t;

endpackage

// ----- design/bds_pix_if.sv -----
// ----------------------------------------------------------------------------
// bds_pix_if
// Source pixel channel: valid/ready handshake and four channel bytes.
// ----------------------------------------------------------------------------
interface bds_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] chan0;
	logic [7:0] chan1;
	logic [7:0] chan2;
	logic [7:0] chan3;

	modport source (output valid, output chan0, output chan1, output chan2, output chan3,
		input ready);
	modport sink (input valid, input chan0, input chan1, input chan2, input chan3,
		output ready);
endinterface

// ----- design/bds_res_if.sv -----
// ----------------------------------------------------------------------------
// bds_res_if
// Result channel: valid/ready handshake, averaged bytes and end markers.
// ----------------------------------------------------------------------------
interface bds_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_chan0;
	logic [7:0] out_chan1;
	logic [7:0] out_chan2;
	logic [7:0] out_chan3;
	logic       row_end;
	logic       frame_end;

	modport source (output valid, output out_chan0, output out_chan1, output out_chan2,
		output out_chan3, output row_end, output frame_end, input ready);
	modport sink (input valid, input out_chan0, input out_chan1, input out_chan2,
		input out_chan3, input row_end, input frame_end, output ready);
endinterface

// ----- design/bds_line_mem.sv -----
// ----------------------------------------------------------------------------
// bds_line_mem
// Single-port line store holding the upper row of each row pair.
// ----------------------------------------------------------------------------
module bds_line_mem #(
	parameter int AW    = 12,
	parameter int DEPTH = 4096,
	parameter int DW    = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic          re,
	input  logic [AW-1:0] addr,
	input  logic [DW-1:0] wdata,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- design/bds_scan.sv -----
// ----------------------------------------------------------------------------
// bds_scan
// Raster position counters and line store addressing for accepted pixels.
// ----------------------------------------------------------------------------
module bds_scan #(
	parameter int MAX_WIDTH = 4096,
	parameter int AW        = 12
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic [bds_pkg::CFG_W-1:0]  image_width,
	input  logic [bds_pkg::CFG_W-1:0]  image_height,
	output logic [AW-1:0]              addr,
	output logic                       mem_we,
	output logic                       mem_re,
	output bds_pkg::scan_info_t        info
);
	import bds_pkg::*;

	// Wide enough for the width register and for MAX_WIDTH itself.
	localparam int CW = (CFG_W > AW + 1) ? CFG_W : AW + 1;
	localparam logic [CW-1:0]    MAX_W_C = CW'(MAX_WIDTH);
	localparam logic [CFG_W-1:0] MAX_H_C = CFG_W'(MAX_HEIGHT);

	logic [AW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	logic [CW-1:0]    w_raw;
	logic [CW-1:0]    w_eff;
	logic [CFG_W-1:0] h_eff;
	logic [CW-1:0]    col_ext;
	logic [CFG_W-1:0] row_inc;
	logic             last_col;
	logic             last_row;
	logic             odd_row;

	always_comb begin
		w_raw = CW'(image_width);
		if (w_raw == '0) begin
			w_eff = CW'(1);
		end else if (w_raw > MAX_W_C) begin
			w_eff = MAX_W_C;
		end else begin
			w_eff = w_raw;
		end

		if (image_height == '0) begin
			h_eff = CFG_W'(1);
		end else if (image_height > MAX_H_C) begin
			h_eff = MAX_H_C;
		end else begin
			h_eff = image_height;
		end

		col_ext  = CW'(col_q);
		row_inc  = CFG_W'(row_q) + CFG_W'(1);
		last_col = (col_ext + CW'(1)) >= w_eff;
		last_row = row_inc >= h_eff;
		odd_row  = row_q[0];

		// A column left beyond a narrowed width maps onto the last one.
		addr = (col_ext < w_eff) ? col_q : AW'(w_eff - CW'(1));

		mem_we = accept && !odd_row && !last_row;
		mem_re = accept && odd_row;

		info.emit      = (odd_row || last_row) && (col_q[0] || last_col);
		info.last_col  = last_col;
		info.last_row  = last_row;
		info.odd_row   = odd_row;
		info.first_col = (col_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_inc[ROW_W-1:0];
			end else begin
				col_q <= col_q + AW'(1);
			end
		end
	end

endmodule

// ----- design/bds_avg.sv -----
// ----------------------------------------------------------------------------
// bds_avg
// Combines the stored and the current pixel, averages each 2x2 block and
// holds the result in the output register.
// ----------------------------------------------------------------------------
module bds_avg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  bds_pkg::scan_info_t            info,
	input  bds_pkg::pix_t                  pix,
	input  bds_pkg::pix_t                  rd_pix,
	input  logic [bds_pkg::CHAN_CNT_W-1:0] nch,
	output logic                           ready,
	bds_res_if.source                      res
);
	import bds_pkg::*;

	logic       valid_s1;
	scan_info_t info_s1;
	pix_t       pix_s1;
	pix_t       prev_up_q;
	pix_t       prev_lo_q;
	logic       out_valid_q;
	pix_t       out_pix_q;
	logic       row_end_q;
	logic       frame_end_q;

	logic       s1_free;
	logic       s1_done;
	pix_t       up;
	pix_t       lo;
	pix_t       lu;
	pix_t       ll;
	pix_t       mean;
	logic [BYTE_W+1:0] sum;

	always_comb begin
		s1_free = !valid_s1 || !out_valid_q || res.ready;
		s1_done = valid_s1 && s1_free;
		ready   = s1_free;

		// Odd rows take the upper pixel from the line store.
		up = info_s1.odd_row ? rd_pix : pix_s1;
		lo = pix_s1;
		lu = info_s1.first_col ? up : prev_up_q;
		ll = info_s1.first_col ? lo : prev_lo_q;

		mean = '0;
		for (int k = 0; k < PORT_CHANNELS; k++) begin
			sum = (BYTE_W+2)'(lu[k]) + (BYTE_W+2)'(up[k]) + (BYTE_W+2)'(ll[k])
				+ (BYTE_W+2)'(lo[k]);
			if (CHAN_CNT_W'(k) < nch) begin
				mean[k] = sum[BYTE_W+1:2];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			prev_up_q   <= '0;
			prev_lo_q   <= '0;
		end else begin
			if (s1_free) begin
				valid_s1 <= accept;
			end
			if (s1_done) begin
				prev_up_q <= up;
				prev_lo_q <= lo;
			end
			if (s1_done && info_s1.emit) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			info_s1 <= info;
			pix_s1  <= pix;
		end
		if (s1_done && info_s1.emit) begin
			out_pix_q   <= mean;
			row_end_q   <= info_s1.last_col;
			frame_end_q <= info_s1.last_col && info_s1.last_row;
		end
	end

	assign res.valid     = out_valid_q;
	assign res.out_chan0 = out_pix_q[0];
	assign res.out_chan1 = out_pix_q[1];
	assign res.out_chan2 = out_pix_q[2];
	assign res.out_chan3 = out_pix_q[3];
	assign res.row_end   = row_end_q;
	assign res.frame_end = frame_end_q;

endmodule

// ----- design/box_downsample_2x2_top.sv -----
// ----------------------------------------------------------------------------
// box_downsample_2x2_top
// Two-by-two box downsampler for a raster pixel stream.
// ----------------------------------------------------------------------------
// Source pixels arrive in raster order, one per transaction, and the block
// takes one pixel every clock cycle for as long as the result side keeps up;
// ready falls only when the output register holds a result that has not been
// taken and the pixel in the second stage also waits. The rate is set by the
// single-port line store, which sees at most one access per pixel: a write on
// even rows, a read on odd rows, and none on the lone last row of an odd
// height. The pixel completing a 2x2 block is registered in the s1 stage,
// where it can wait on a full output register, and its result is then loaded
// into the output register, which drives res.valid. Each result is the
// truncated mean (a+b+c+d)>>2 of every channel in use; channels at or above
// the count in use read zero. With an odd width the last column is paired with
// the column to its left (or itself when the width is one), and with an odd
// height the lone last row is paired with itself. The line store has no reset
// and needs no clearing pass: every entry an odd row reads was written by the
// even row before it. Configuration should only be written while the block
// is idle.
// ----------------------------------------------------------------------------
module box_downsample_2x2_top #(
	parameter int MAX_WIDTH    = 4096,
	parameter int MAX_CHANNELS = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	bds_pix_if.sink                       pix,
	bds_res_if.source                     res,
	input  logic                          cfg_we,
	input  logic [bds_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bds_pkg::CFG_W-1:0]     cfg_wdata
);
	import bds_pkg::*;

	// Address width of the line store and the number of byte lanes it keeps.
	localparam int AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int LANES = (MAX_CHANNELS < PORT_CHANNELS) ? MAX_CHANNELS : PORT_CHANNELS;
	localparam int DW    = LANES * BYTE_W;
	localparam logic [CHAN_CNT_W-1:0] LANES_C = CHAN_CNT_W'(LANES);

	// Configuration registers; the user must write them only while the block is idle, the block does not enforce it.
	logic [CFG_W-1:0]      width_q;
	logic [CFG_W-1:0]      height_q;
	logic [CHAN_CNT_W-1:0] chans_q;
	logic [CHAN_CNT_W-1:0] nch;

	logic                  accept;
	logic                  s_ready;
	logic [AW-1:0]         addr;
	logic                  mem_we;
	logic                  mem_re;
	scan_info_t            info;
	pix_t                  in_pix;
	pix_t                  rd_pix;
	logic [DW-1:0]         wdata;
	logic [DW-1:0]         rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(1);
			height_q <= CFG_W'(1);
			chans_q  <= CHAN_CNT_W'(4);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:   width_q  <= cfg_wdata;
				REG_IMAGE_HEIGHT:  height_q <= cfg_wdata;
				REG_CHANNEL_COUNT: chans_q  <= cfg_wdata[CHAN_CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// A channel count of zero means one; anything above the stored lanes
	// saturates.
	always_comb begin
		if (chans_q == '0) begin
			nch = CHAN_CNT_W'(1);
		end else if (chans_q > LANES_C) begin
			nch = LANES_C;
		end else begin
			nch = chans_q;
		end
	end

	assign accept    = pix.valid && s_ready;
	assign pix.ready = s_ready;

	// Pack the incoming pixel and map it onto the lanes of the line store.
	always_comb begin
		in_pix[0] = pix.chan0;
		in_pix[1] = pix.chan1;
		in_pix[2] = pix.chan2;
		in_pix[3] = pix.chan3;
		rd_pix    = '0;
		for (int k = 0; k < LANES; k++) begin
			wdata[k*BYTE_W +: BYTE_W] = in_pix[k];
			rd_pix[k]                 = rdata[k*BYTE_W +: BYTE_W];
		end
	end

	bds_scan #(
		.MAX_WIDTH (MAX_WIDTH),
		.AW        (AW)
	) u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.image_width  (width_q),
		.image_height (height_q),
		.addr         (addr),
		.mem_we       (mem_we),
		.mem_re       (mem_re),
		.info         (info)
	);

	bds_line_mem #(
		.AW    (AW),
		.DEPTH (MAX_WIDTH),
		.DW    (DW)
	) u_line_mem (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (addr),
		.wdata (wdata),
		.rdata (rdata)
	);

	bds_avg u_avg (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.info   (info),
		.pix    (in_pix),
		.rd_pix (rd_pix),
		.nch    (nch),
		.ready  (s_ready),
		.res    (res)
	);

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 2x2 box downsampler.
// ----------------------------------------------------------------------------
// Pixels are sent over the source channel in bursts with random gaps. A
// result sink with its own stall pattern takes the means. Every accepted
// pixel is run through a cycle-free model of the downsampler, and the means
// that it produces are queued and compared field by field with what the
// block returns.
// ----------------------------------------------------------------------------
module testbench;
	import bds_pkg::*;

	// Line store depth and channel limit of the instance under test.
	localparam int LINE_DEPTH = 4096;
	localparam int CHANNEL_LIMIT = 4;

	// A result passes the s1 stage and the output register after the transaction
	// of the pixel that completes its block; the settling wait leaves room for the
	// pixel still in flight and for the output register.
	localparam int SETTLE_CYCLES = 8;

	// Length of the long hold-off on the result side that fills the block.
	localparam int HOLD_CYCLES = 150;

	// Some 350 random pixels are sent after the directed and size tests,
	// about 500 in all.
	localparam int RANDOM_PIXELS = 350;

	// The run sends some 500 pixels, the last random frame perhaps a few
	// hundred more. Each can wait out a sender gap, a receiver stall and the
	// block's own pipeline, and the settling around the register writes and
	// the one long hold-off add to that. The limit lies well above the total.
	localparam int CYCLE_LIMIT = 200_000;

	// Register index that no register answers to.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef enum logic [1:0] {SINK_STEADY, SINK_COIN, SINK_PATTERN} sink_mode_t;

	// One expected result: the four averaged bytes and the end markers.
	typedef struct packed {
		pix_t chans;
		logic row_end;
		logic frame_end;
	} block_mean_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	bds_pix_if pix_ch ();
	bds_res_if res_ch ();

	box_downsample_2x2_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix       (pix_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Means that the model has worked out and the block has yet to deliver.
	block_mean_t expected_means [$];

	// Model state: register copies as the block holds them, the upper row,
	// the pixels of the column to the left and the position in the frame.
	logic [CFG_W-1:0]      cfg_width = 1;
	logic [CFG_W-1:0]      cfg_height = 1;
	logic [CHAN_CNT_W-1:0] cfg_channels = 4;
	pix_t                  upper_line [LINE_DEPTH] = '{default: '0};
	pix_t                  prev_upper = '0;
	pix_t                  prev_lower = '0;
	int unsigned           col_pos = 0;
	int unsigned           row_pos = 0;

	int unsigned error_count = 0;
	int unsigned pixels_sent = 0;
	int unsigned burst_left = 0;
	int unsigned cycle_count = 0;

	// The test side asks for a hold-off by raising hold_requests; the sink
	// counts the requests it has served in hold_served. Each has one writer.
	int unsigned hold_requests = 0;
	int unsigned hold_served = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run-away guard: a hang anywhere ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Widths and heights as the block uses them: zero counts as one, and
	// anything beyond the largest size is held at that size.
	function automatic int unsigned used_width();
		if (cfg_width == 0)
			return 1;
		if (cfg_width > LINE_DEPTH)
			return LINE_DEPTH;
		return cfg_width;
	endfunction

	function automatic int unsigned used_height();
		if (cfg_height == 0)
			return 1;
		if (cfg_height > MAX_HEIGHT)
			return MAX_HEIGHT;
		return cfg_height;
	endfunction

	// Steps the model by one accepted pixel and queues the mean that it
	// completes, if any.
	task automatic downsample_pixel(input pix_t p);
		int unsigned w, h, nch, c, r, idx, sum;
		bit          last_col, last_row, odd_row;
		pix_t        up, lo, lu, ll;
		block_mean_t mean;
		w = used_width();
		h = used_height();
		nch = (cfg_channels == 0) ? 1 : cfg_channels;
		if (nch > CHANNEL_LIMIT)
			nch = CHANNEL_LIMIT;
		c = col_pos;
		r = row_pos;
		// A position left beyond the end by a register change counts as the
		// last one, so the row or the frame closes at once.
		last_col = (c + 1 >= w);
		last_row = (r + 1 >= h);
		odd_row = r[0];
		idx = (c < w) ? c : (w - 1);

		// Even rows fill the line store, odd rows read it back. A lone last
		// row of an odd height is paired with itself and leaves the store
		// alone.
		if (odd_row) begin
			up = upper_line[idx];
			lo = p;
		end else if (last_row) begin
			up = p;
			lo = p;
		end else begin
			upper_line[idx] = p;
			up = p;
			lo = p;
		end

		// Odd columns close a block; so does the last column of an odd
		// width, which pairs with its left neighbour, or with itself when
		// the width is one.
		if ((odd_row || last_row) && (c[0] || last_col)) begin
			lu = (c == 0) ? up : prev_upper;
			ll = (c == 0) ? lo : prev_lower;
			for (int k = 0; k < PORT_CHANNELS; k++) begin
				sum = lu[k] + up[k] + ll[k] + lo[k];
				mean.chans[k] = (k < nch) ? 8'(sum >> 2) : 8'h00;
			end
			mean.row_end = last_col;
			mean.frame_end = last_col && last_row;
			expected_means.push_back(mean);
		end

		prev_upper = up;
		prev_lower = lo;
		if (last_col) begin
			col_pos = 0;
			row_pos = last_row ? 0 : (r + 1);
		end else begin
			col_pos = c + 1;
		end
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at cycle %0d: %s got %0d, expected %0d", cycle_count, what, got,
			want);
		error_count++;
	endtask

	// Entered and left just after a falling edge, like every task below. The
	// sender works in bursts: at the start of each it may sit idle a while,
	// and now and then a long burst runs with no gap at all. Valid stays high
	// after a transaction; whoever stops sending lowers it.
	task automatic send_pixel(input pix_t p);
		int unsigned gap;
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) == 0) begin
				burst_left = $urandom_range(30, 80);
				gap = 0;
			end else begin
				burst_left = $urandom_range(1, 16);
				gap = $urandom_range(0, 6);
			end
			if (gap != 0) begin
				pix_ch.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		pix_ch.valid = 1'b1;
		pix_ch.chan0 = p[0];
		pix_ch.chan1 = p[1];
		pix_ch.chan2 = p[2];
		pix_ch.chan3 = p[3];
		do @(posedge clk); while (pix_ch.ready !== 1'b1);
		downsample_pixel(p);
		pixels_sent++;
		burst_left--;
		@(negedge clk);
	endtask

	// Stops sending and waits until every expected mean has come back, then
	// lets the pipeline run dry, since the last pixels may have given no
	// result and still be in flight.
	task automatic settle();
		pix_ch.valid = 1'b0;
		while (expected_means.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// One register write. With hold_enable set the enable stays high for a
	// write that follows straight after.
	task automatic write_register(input logic [CFG_IDX_W-1:0] index,
		input logic [CFG_W-1:0] value, input bit hold_enable = 1'b0);
		cfg_we = 1'b1;
		cfg_index = index;
		cfg_wdata = value;
		@(posedge clk);
		case (index)
			REG_IMAGE_WIDTH: cfg_width = value;
			REG_IMAGE_HEIGHT: cfg_height = value;
			REG_CHANNEL_COUNT: cfg_channels = value[CHAN_CNT_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		if (!hold_enable)
			cfg_we = 1'b0;
	endtask

	task automatic configure(input logic [CFG_W-1:0] width, input logic [CFG_W-1:0] height,
		input logic [CFG_W-1:0] channels);
		settle();
		write_register(REG_IMAGE_WIDTH, width, 1'b1);
		write_register(REG_IMAGE_HEIGHT, height, 1'b1);
		write_register(REG_CHANNEL_COUNT, channels);
	endtask

	// Channel bytes lean towards both extremes so that saturated sums and
	// zero sums turn up often.
	function automatic pix_t random_pixel();
		pix_t p;
		for (int k = 0; k < PORT_CHANNELS; k++) begin
			case ($urandom_range(0, 7))
				0: p[k] = 8'h00;
				1: p[k] = 8'hFF;
				default: p[k] = 8'($urandom);
			endcase
		end
		return p;
	endfunction

	// The sink stalls on a pattern of its own: spells of steady readiness,
	// spells of coin tosses and spells that follow a random bit pattern. A
	// hold-off request overrides all of these while it lasts.
	initial begin : result_sink
		sink_mode_t  mode;
		int unsigned phase_left;
		int unsigned hold_left;
		logic [15:0] pattern;
		mode = SINK_STEADY;
		phase_left = 0;
		hold_left = 0;
		pattern = '1;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_served != hold_requests) begin
				hold_served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				res_ch.ready = 1'b0;
				hold_left--;
			end else begin
				if (phase_left == 0) begin
					mode = sink_mode_t'($urandom_range(0, 2));
					phase_left = $urandom_range(8, 48);
					pattern = 16'($urandom) | 16'h0001;
				end
				phase_left--;
				case (mode)
					SINK_STEADY: res_ch.ready = 1'b1;
					SINK_COIN: res_ch.ready = 1'($urandom_range(0, 1));
					SINK_PATTERN: res_ch.ready = pattern[phase_left % 16];
					default: res_ch.ready = 1'b1;
				endcase
			end
		end
	end

	// Every result transaction is matched against the oldest expected mean.
	always @(posedge clk) begin : check_means
		block_mean_t want;
		pix_t        got;
		if (arst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			got = {res_ch.out_chan3, res_ch.out_chan2, res_ch.out_chan1, res_ch.out_chan0};
			if (expected_means.size() == 0) begin
				report_mismatch("result with nothing expected, out_chan0", got[0], -1);
			end else begin
				want = expected_means.pop_front();
				for (int k = 0; k < PORT_CHANNELS; k++) begin
					if (got[k] !== want.chans[k])
						report_mismatch($sformatf("out_chan%0d", k), got[k], want.chans[k]);
				end
				if (res_ch.row_end !== want.row_end)
					report_mismatch("row_end", res_ch.row_end, want.row_end);
				if (res_ch.frame_end !== want.frame_end)
					report_mismatch("frame_end", res_ch.frame_end, want.frame_end);
			end
		end
	end

	// The registers as they come out of reset: a 1x1 frame with all four
	// channels, so every pixel is its own mean and ends both row and frame.
	task automatic test_reset_defaults();
		send_pixel(32'h0000_0000);
		send_pixel(32'hFFFF_FFFF);
	endtask

	// Small hand-made frames: odd width and odd height, the unused register
	// index, zero and oversized register values, and a width cut short in
	// the middle of an odd row.
	task automatic test_directed_frames();
		pix_t grid [9];
		grid = '{32'hFF00_0000, 32'h01FF_0102, 32'h7F80_FF03, 32'h0000_FFFF, 32'hFEFF_0001,
			32'h8081_7F02, 32'h0302_0100, 32'hFFFF_FFFF, 32'h5AA5_C33C};

		// A write to the unused index must change nothing.
		settle();
		write_register(REG_UNUSED, 13'h1FFF);
		configure(13'd3, 13'd3, 13'd4);
		foreach (grid[i])
			send_pixel(grid[i]);

		// Width one with two rows and a channel count of zero, taken as one.
		configure(13'd1, 13'd2, 13'd0);
		send_pixel(32'hA5C3_7E81);
		send_pixel(32'h5A3C_8118);

		// Zero sizes count as one; seven channels are held at four.
		configure(13'd0, 13'd0, 13'd7);
		send_pixel(32'h8001_FE7F);

		// Three channels in use. Half way through the odd row the width
		// drops to two, so the next pixel sits beyond the new last column
		// and closes both the row and the frame.
		configure(13'd4, 13'd2, 13'd3);
		repeat (6) send_pixel(random_pixel());
		settle();
		write_register(REG_IMAGE_WIDTH, 13'd2);
		send_pixel(random_pixel());
	endtask

	// Widest and tallest frames, as set and through saturation, each cut
	// short by a register change so that only a few pixels are needed. The
	// first one also writes the forty lowest entries of the line store, so
	// that later register changes in mid-frame, which never reach beyond a
	// width of forty, can never read an entry that was never written.
	task automatic test_extreme_sizes();
		// Forty pixels of the upper row, then a width of one: the next pixel
		// closes the upper row and the one after it closes the frame.
		configure(13'd4096, 13'd2, 13'd4);
		repeat (40) send_pixel(random_pixel());
		settle();
		write_register(REG_IMAGE_WIDTH, 13'd1);
		repeat (2) send_pixel(random_pixel());

		// An oversized width is held at the largest one; a zero width then
		// closes the single row at once.
		configure(13'h1FFF, 13'd1, 13'd4);
		repeat (5) send_pixel(random_pixel());
		settle();
		write_register(REG_IMAGE_WIDTH, 13'd0);
		send_pixel(random_pixel());

		// The tallest frame, closed on an even row that pairs with itself.
		configure(13'd1, 13'd4096, 13'd1);
		repeat (6) send_pixel(random_pixel());
		settle();
		write_register(REG_IMAGE_HEIGHT, 13'd1);
		send_pixel(random_pixel());

		// An oversized height, closed on an odd row that reads the store.
		configure(13'd1, 13'h1FFF, 13'd2);
		repeat (5) send_pixel(random_pixel());
		settle();
		write_register(REG_IMAGE_HEIGHT, 13'd0);
		send_pixel(random_pixel());
	endtask

	// The sink holds off for a long stretch while the sender keeps offering
	// pixels without a gap, so the block fills up and must stall its input.
	task automatic test_back_pressure();
		configure(13'd6, 13'd4, 13'd4);
		hold_requests++;
		burst_left = 48;
		repeat (48) send_pixel(random_pixel());
		burst_left = 0;
	endtask

	// Mostly whole frames of random size and content. About one frame in
	// four is broken off part way: the block is let run dry, one register write is made,
	// at times to the unused index, and the frame is then run to its end under the new values.
	task automatic test_random_frames();
		int unsigned start_count;
		int unsigned width_pick;
		logic [CFG_W-1:0] width;
		start_count = pixels_sent;
		while (pixels_sent - start_count < RANDOM_PIXELS) begin
			width_pick = $urandom_range(0, 19);
			if (width_pick == 0)
				width = 13'd0;
			else if (width_pick < 4)
				width = 13'($urandom_range(13, 40));
			else
				width = 13'($urandom_range(1, 12));
			configure(width, 13'($urandom_range(0, 6)), 13'($urandom));
			if ($urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(1, used_width() * used_height()))
					send_pixel(random_pixel());
				settle();
				case ($urandom_range(0, 3))
					0: write_register(REG_IMAGE_WIDTH, 13'($urandom_range(0, 12)));
					1: write_register(REG_IMAGE_HEIGHT, 13'($urandom_range(0, 12)));
					2: write_register(REG_CHANNEL_COUNT, 13'($urandom));
					default: write_register(REG_UNUSED, 13'($urandom));
				endcase
			end
			do send_pixel(random_pixel()); while (row_pos != 0 || col_pos != 0);
		end
	endtask

	initial begin
		pix_ch.valid = 1'b0;
		pix_ch.chan0 = '0;
		pix_ch.chan1 = '0;
		pix_ch.chan2 = '0;
		pix_ch.chan3 = '0;
		cfg_we = 1'b0;
		cfg_index = REG_IMAGE_WIDTH;
		cfg_wdata = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_directed_frames();
		test_extreme_sizes();
		test_back_pressure();
		test_random_frames();

		// Everything has been sent; wait for the last means and a little
		// longer, so that a stray extra result is still caught.
		settle();
		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ----- sim.f -----
design/bds_pkg.sv
design/bds_pix_if.sv
design/bds_res_if.sv
design/bds_line_mem.sv
design/bds_scan.sv
design/bds_avg.sv
design/box_downsample_2x2_top.sv
tb/sv/testbench.sv
